FILE: hw/rtl/pbf_pkg.sv
// Shared types and constants for the byte pipe FIFO.
// No dependencies; used by pbf_ram, pbf_ends and pipe_byte_fifo.
`default_nettype none

package pbf_pkg;

    localparam int DATA_W = 8;
    localparam int MODE_W = 2;
    localparam int FILL_W = 13;
    localparam int STAT_W = 3;

    localparam logic [MODE_W-1:0] WRITE_ONLY_RESET = 2'd1;

    typedef enum logic [1:0] {
        FUNC_WRITE = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_OPEN  = 2'd2,
        FUNC_CLOSE = 2'd3
    } func_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK            = 3'd0,
        ST_EMPTY_BLOCK   = 3'd1,
        ST_END_OF_STREAM = 3'd2,
        ST_FULL_BLOCK    = 3'd3,
        ST_BROKEN_PIPE   = 3'd4
    } status_t;

    // update request to the end counters
    typedef struct packed {
        logic open_end;
        logic close_end;
        logic writer;
    } ends_cmd_t;

    // end counter state as seen by the datapath
    typedef struct packed {
        logic reader_none;      // current reader count is zero
        logic writer_none;      // current writer count is zero
        logic all_closed_next;  // both counts zero after this command
    } ends_stat_t;

endpackage : pbf_pkg

`default_nettype wire

FILE: hw/rtl/pbf_ram.sv
// Byte store: simple dual-port synchronous RAM, registered read data.
// Depends on pbf_pkg for the data width.
`default_nettype none

module pbf_ram
    import pbf_pkg::*;
#(
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read data holds until the next read is issued
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule : pbf_ram

`default_nettype wire

FILE: hw/rtl/pbf_ends.sv
// Open reader and writer end counters, saturating at MAX_ENDS and at zero.
// Depends on pbf_pkg for the command and status structs.
`default_nettype none

module pbf_ends
    import pbf_pkg::*;
#(
    parameter int MAX_ENDS = 255,
    parameter int CNT_W    = 8
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire ends_cmd_t  cmd,
    output ends_stat_t      stat
);

    logic [CNT_W-1:0] reader_reg, reader_next;
    logic [CNT_W-1:0] writer_reg, writer_next;
    logic [CNT_W-1:0] sel_cnt, sel_next;

    always_comb
    begin
        sel_cnt  = cmd.writer ? writer_reg : reader_reg;
        sel_next = sel_cnt;
        if (cmd.open_end && (sel_cnt < CNT_W'(MAX_ENDS)))
        begin
            sel_next = sel_cnt + CNT_W'(1);
        end
        else if (cmd.close_end && (sel_cnt != '0))
        begin
            sel_next = sel_cnt - CNT_W'(1);
        end
        reader_next = cmd.writer ? reader_reg : sel_next;
        writer_next = cmd.writer ? sel_next : writer_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reader_reg <= CNT_W'(1);
            writer_reg <= CNT_W'(1);
        end
        else
        begin
            reader_reg <= reader_next;
            writer_reg <= writer_next;
        end
    end

    assign stat.reader_none     = (reader_reg == '0);
    assign stat.writer_none     = (writer_reg == '0);
    assign stat.all_closed_next = (reader_next == '0) && (writer_next == '0);

endmodule : pbf_ends

`default_nettype wire

FILE: hw/rtl/pipe_byte_fifo.sv
// Top level of the byte pipe FIFO: handshake, pointers, fill count, result pipeline.
// Depends on pbf_pkg, pbf_ram and pbf_ends.
`default_nettype none

// Byte pipe FIFO. Each input transfer carries one operation (write byte,
// read byte, open end, close end) and yields exactly one result transfer.
// The block takes one item per cycle while the result side keeps up; a
// result passes through stage 1, which waits on the registered read of the
// byte memory (one write port, one read port), and then the output register.
// Pointers, fill count and end counts update in the accept cycle, so
// consecutive items see each other's effects with no bubble. Stalls on the
// result side back up through a one-item stage into in_stall. The byte
// memory needs no clearing after reset. cfg_ready is always high; write
// cfg_data only while the block is idle.
module pipe_byte_fifo
    import pbf_pkg::*;
#(
    parameter int STORE_DEPTH = 4096,
    parameter int MAX_ENDS    = 255
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    // configuration
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [MODE_W-1:0] cfg_data,
    // items in
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [1:0]        func,
    input  wire logic [DATA_W-1:0] data_in,
    input  wire logic [MODE_W-1:0] access_mode,
    input  wire logic              last_of_request,
    // results out
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [DATA_W-1:0]      data_out,
    output logic [STAT_W-1:0]      status,
    output logic [FILL_W-1:0]      fill_count,
    output logic                   all_ends_closed,
    output logic                   request_done
);

    localparam int PTR_W  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int HELD_W = $clog2(STORE_DEPTH + 1);
    localparam int ENDS_W = $clog2(MAX_ENDS + 1);

    logic [MODE_W-1:0] mode_reg;

    logic [PTR_W-1:0]  wpos_reg,  wpos_next;
    logic [PTR_W-1:0]  rpos_reg,  rpos_next;
    logic [HELD_W-1:0] held_reg,  held_next;

    // stage 1: item decided, waiting on memory read data
    logic              s1_valid_reg,  s1_valid_next;
    logic              s1_rd_ok_reg;
    status_t           s1_status_reg;
    logic [FILL_W-1:0] s1_fill_reg;
    logic              s1_closed_reg;
    logic              s1_last_reg;

    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] out_data_reg;
    status_t           out_status_reg;
    logic [FILL_W-1:0] out_fill_reg;
    logic              out_closed_reg;
    logic              out_last_reg;

    logic              s1_advance;
    logic              accept;
    func_t             op;
    logic              store_full;
    logic              store_empty;
    logic              wr_ok;
    logic              rd_ok;
    status_t           status_calc;
    ends_cmd_t         ends_cmd;
    ends_stat_t        ends_stat;
    logic [DATA_W-1:0] ram_rdata;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= WRITE_ONLY_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            mode_reg <= cfg_data;
        end
    end

    assign s1_advance = !out_valid_reg || !out_stall;
    assign in_stall   = s1_valid_reg && !s1_advance;
    assign accept     = in_valid && !in_stall;
    assign op         = func_t'(func);

    assign store_full  = (held_reg == HELD_W'(STORE_DEPTH));
    assign store_empty = (held_reg == '0);

    assign ends_cmd.open_end  = accept && (op == FUNC_OPEN);
    assign ends_cmd.close_end = accept && (op == FUNC_CLOSE);
    assign ends_cmd.writer    = (access_mode == mode_reg);

    pbf_ends #(
        .MAX_ENDS (MAX_ENDS),
        .CNT_W    (ENDS_W)
    ) u_ends (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (ends_cmd),
        .stat  (ends_stat)
    );

    always_comb
    begin
        wr_ok       = 1'b0;
        rd_ok       = 1'b0;
        status_calc = ST_OK;
        unique case (op)
            FUNC_WRITE:
            begin
                if (ends_stat.reader_none)
                begin
                    status_calc = ST_BROKEN_PIPE;
                end
                else if (store_full)
                begin
                    status_calc = ST_FULL_BLOCK;
                end
                else
                begin
                    wr_ok = 1'b1;
                end
            end
            FUNC_READ:
            begin
                if (!store_empty)
                begin
                    rd_ok = 1'b1;
                end
                else if (ends_stat.writer_none)
                begin
                    status_calc = ST_END_OF_STREAM;
                end
                else
                begin
                    status_calc = ST_EMPTY_BLOCK;
                end
            end
            FUNC_OPEN, FUNC_CLOSE:
            begin
                status_calc = ST_OK;
            end
            default:
            begin
                status_calc = ST_OK;
            end
        endcase
    end

    always_comb
    begin
        wpos_next = wpos_reg;
        rpos_next = rpos_reg;
        held_next = held_reg;
        if (accept && wr_ok)
        begin
            wpos_next = (wpos_reg == PTR_W'(STORE_DEPTH - 1)) ? '0 : wpos_reg + PTR_W'(1);
            held_next = held_reg + HELD_W'(1);
        end
        else if (accept && rd_ok)
        begin
            rpos_next = (rpos_reg == PTR_W'(STORE_DEPTH - 1)) ? '0 : rpos_reg + PTR_W'(1);
            held_next = held_reg - HELD_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wpos_reg <= '0;
            rpos_reg <= '0;
            held_reg <= '0;
        end
        else
        begin
            wpos_reg <= wpos_next;
            rpos_reg <= rpos_next;
            held_reg <= held_next;
        end
    end

    // only one item per cycle touches the memory, so a read and a write
    // never hit the same entry in the same cycle
    pbf_ram #(
        .DEPTH  (STORE_DEPTH),
        .ADDR_W (PTR_W)
    ) u_ram (
        .clk   (clk),
        .we    (accept && wr_ok),
        .waddr (wpos_reg),
        .wdata (data_in),
        .re    (accept && rd_ok),
        .raddr (rpos_reg),
        .rdata (ram_rdata)
    );

    assign s1_valid_next  = accept || (s1_valid_reg && !s1_advance);
    assign out_valid_next = s1_advance ? s1_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_rd_ok_reg  <= rd_ok;
            s1_status_reg <= status_calc;
            s1_fill_reg   <= FILL_W'(held_next);
            s1_closed_reg <= ends_stat.all_closed_next;
            s1_last_reg   <= last_of_request;
        end
    end

    // read data is stable while stage 1 holds: a new read only issues on
    // the same edge that moves stage 1 on
    always_ff @(posedge clk)
    begin
        if (s1_advance && s1_valid_reg)
        begin
            out_data_reg   <= s1_rd_ok_reg ? ram_rdata : '0;
            out_status_reg <= s1_status_reg;
            out_fill_reg   <= s1_fill_reg;
            out_closed_reg <= s1_closed_reg;
            out_last_reg   <= s1_last_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign data_out        = out_data_reg;
    assign status          = out_status_reg;
    assign fill_count      = out_fill_reg;
    assign all_ends_closed = out_closed_reg;
    assign request_done    = out_last_reg;

endmodule : pipe_byte_fifo

`default_nettype wire
